FILE: design/bb_pkg.sv
package bb_pkg;

   // Widths of one colour channel, a three-pixel column sum and a nine-pixel sum.
   localparam int CHAN_W = 8;
   localparam int PIX_W  = 3 * CHAN_W;
   localparam int COL_W  = 10;
   localparam int SUM_W  = 12;

   // Configuration register file.
   localparam int CFG_W  = 11;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // Floor division by nine as a multiply by a rounded-up reciprocal.
   // Exact for every sum of nine 8-bit channels.
   localparam int DIV9_SHIFT = 15;
   localparam logic [SUM_W-1:0] DIV9_MUL = 12'd3641;

   // Channel order in every packed pixel and sum: red, green, blue.
   typedef struct packed {
      logic [2:0][SUM_W-1:0] chan;
      logic                  last;
   } bb_sum_type;

   function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] x);
      logic [2*SUM_W-1:0] prod;
      prod = (2*SUM_W)'(x) * (2*SUM_W)'(DIV9_MUL);
      return prod[DIV9_SHIFT +: CHAN_W];
   endfunction

endpackage

FILE: design/bb_ram.sv
module bb_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/bb_csr.sv
module bb_csr #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [bb_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [bb_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [bb_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                        csr_pready,
   output logic [$clog2(MAX_WIDTH+1)-1:0]  width_eff,
   output logic [$clog2(MAX_HEIGHT+2)-1:0] height_eff,
   output logic                        cfg_restart
);
   import bb_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 2);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             wr_fire;
   logic [31:0]      width_raw, height_raw, width_clamp, height_clamp;

   // A write transaction completes in the access phase; any write restarts the frame.
   assign wr_fire     = csr_psel && csr_penable && csr_pwrite;
   assign cfg_restart = wr_fire;
   assign csr_pready  = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_fire) begin
         case (csr_paddr[2])
            REG_FRAME_WIDTH:  width_in  = csr_pwdata[CFG_W-1:0];
            REG_FRAME_HEIGHT: height_in = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_RESET;
         height_ff <= CFG_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Read back the raw register values.
   always_comb begin
      case (csr_paddr[2])
         REG_FRAME_WIDTH:  csr_prdata = CSR_DW'(width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DW'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Zero acts as one and anything above the maximum acts as the maximum.
   always_comb begin
      width_raw  = 32'(width_ff);
      height_raw = 32'(height_ff);
      if (width_raw == 32'd0) begin
         width_clamp = 32'd1;
      end else if (width_raw > 32'(MAX_WIDTH)) begin
         width_clamp = 32'(MAX_WIDTH);
      end else begin
         width_clamp = width_raw;
      end
      if (height_raw == 32'd0) begin
         height_clamp = 32'd1;
      end else if (height_raw > 32'(MAX_HEIGHT)) begin
         height_clamp = 32'(MAX_HEIGHT);
      end else begin
         height_clamp = height_raw;
      end
   end

   assign width_eff  = WW'(width_clamp);
   assign height_eff = HW'(height_clamp);

endmodule

FILE: design/bb_divide.sv
module bb_divide (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  sum_valid,
   output logic                  sum_ready,
   input  bb_pkg::bb_sum_type    sum_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [bb_pkg::CHAN_W-1:0] rsp_red,
   output logic [bb_pkg::CHAN_W-1:0] rsp_green,
   output logic [bb_pkg::CHAN_W-1:0] rsp_blue,
   output logic                  rsp_last
);
   import bb_pkg::*;

   logic                   sum_v_ff, sum_v_in;
   bb_sum_type             sum_ff;
   logic                   out_v_ff, out_v_in;
   logic [2:0][CHAN_W-1:0] out_ff, quot;
   logic                   out_last_ff;
   logic                   sum_adv;

   // The sum register moves on whenever the output register is empty or being taken.
   assign sum_adv   = sum_v_ff && (!out_v_ff || rsp_ready);
   assign sum_ready = !sum_v_ff || sum_adv;

   always_comb begin
      sum_v_in = sum_v_ff;
      if (sum_valid && sum_ready) begin
         sum_v_in = 1'b1;
      end else if (sum_adv) begin
         sum_v_in = 1'b0;
      end
      out_v_in = out_v_ff;
      if (sum_adv) begin
         out_v_in = 1'b1;
      end else if (rsp_ready) begin
         out_v_in = 1'b0;
      end
   end

   // Divide each channel sum by nine.
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         quot[ch] = div9(sum_ff.chan[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         sum_v_ff <= sum_v_in;
         out_v_ff <= out_v_in;
      end
      if (sum_valid && sum_ready) begin
         sum_ff <= sum_data;
      end
      if (sum_adv) begin
         out_ff      <= quot;
         out_last_ff <= sum_ff.last;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_red   = out_ff[0];
   assign rsp_green = out_ff[1];
   assign rsp_blue  = out_ff[2];
   assign rsp_last  = out_last_ff;

endmodule

FILE: design/box_blur_3x3.sv
// 3x3 box blur over an RGB frame streamed in raster order, zero padded at the edges.
// Input channel (req_): one pixel per transaction; req_drain marks a transaction that
// carries no pixel and only pushes the window on. After the last pixel of a frame,
// frame_width + 1 drain transactions must follow to flush the final row.
// Result channel (rsp_): the blurred pixel, floor of the neighbourhood sum over nine,
// with rsp_last on the final pixel of the frame. The result for a pixel is caused by
// the transaction frame_width + 1 places later and passes through the read stage and
// the divider's sum and output registers before it is shown on rsp_.
// Throughput is one transaction per cycle without back-pressure: the line store is a
// single dual-port RAM read at accept and written back as the transaction leaves
// the read stage, with a bypass for a column read and written on the same edge.
// Configuration port (csr_): frame_width at address 0, frame_height at address 4.
// Any write restarts the frame; write only while the block is idle.
// Reset sets both dimensions to 1024 and the position to the start of a frame.
// The line RAM is not cleared; its stale entries are always masked as off-frame.
// When the receiver stalls, up to three results are held (read stage, sum register,
// output register) and req_ready drops once they are all full.
module box_blur_3x3 #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_red,
   input  logic [7:0]                  req_green,
   input  logic [7:0]                  req_blue,
   input  logic                        req_drain,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_red,
   output logic [7:0]                  rsp_green,
   output logic [7:0]                  rsp_blue,
   output logic                        rsp_last,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [bb_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [bb_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [bb_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                        csr_pready
);
   import bb_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 2);
   localparam int LW = 2 * PIX_W;

   logic [WW-1:0]    width_eff;
   logic [HW-1:0]    height_eff;
   logic             cfg_restart;

   logic [AW-1:0]    col_ff, col_in, col_cur;
   logic [HW-1:0]    row_ff, row_in;

   logic             req_accept, drop, load, emit, last, wrap, fwd_hit;
   logic [PIX_W-1:0] pix;

   logic             s1_v_ff, s1_v_in, s1_adv;
   logic [AW-1:0]    s1_addr_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic             s1_top_keep_ff, s1_mid_keep_ff, s1_emit_ff, s1_last_ff;
   logic             s1_keep0_ff, s1_keep2_ff, s1_fwd_ff;
   logic [LW-1:0]    s1_fwd_data_ff;

   logic [LW-1:0]    ram_rd, lines, wb_data;
   logic [PIX_W-1:0] top_px, mid_px;

   logic [COL_W-1:0] win_ff [3][3];
   logic [COL_W-1:0] win_in [3][3];
   logic [COL_W-1:0] new_col [3];
   logic [CHAN_W-1:0] top_ch, mid_ch;

   bb_sum_type       sum_fixed;
   logic             sum_ready;

   bb_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .width_eff   (width_eff),
      .height_eff  (height_eff),
      .cfg_restart (cfg_restart)
   );

   // Frame position and what the accepted transaction means at that position.
   assign col_cur    = (WW'(col_ff) >= width_eff) ? '0 : col_ff;
   assign req_accept = req_valid && req_ready;
   assign drop       = req_drain && (row_ff == '0) && (col_cur == '0);
   assign load       = req_accept && !drop;
   assign pix        = (!req_drain && (row_ff < height_eff)) ? {req_red, req_green, req_blue}
                                                             : '0;
   assign emit       = (row_ff >= HW'(2)) || ((row_ff == HW'(1)) && (col_cur != '0));
   assign last       = emit && (col_cur == '0) && (row_ff == height_eff + HW'(1));
   assign wrap       = (WW'(col_cur) + WW'(1)) >= width_eff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_restart) begin
         col_in = '0;
         row_in = '0;
      end else if (load) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (wrap) begin
            col_in = '0;
            row_in = row_ff + HW'(1);
         end else begin
            col_in = col_cur + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Read stage: holds the transaction while the line RAM data arrives.
   assign s1_adv    = s1_v_ff && (!s1_emit_ff || sum_ready);
   assign req_ready = !s1_v_ff || s1_adv;
   assign fwd_hit   = s1_adv && (s1_addr_ff == col_cur);

   always_comb begin
      s1_v_in = s1_v_ff;
      if (load) begin
         s1_v_in = 1'b1;
      end else if (s1_adv) begin
         s1_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
      end
      if (load) begin
         s1_addr_ff     <= col_cur;
         s1_pix_ff      <= pix;
         s1_top_keep_ff <= row_ff >= HW'(2);
         s1_mid_keep_ff <= row_ff != '0;
         s1_emit_ff     <= emit;
         s1_last_ff     <= last;
         s1_keep0_ff    <= !((col_cur == AW'(1)) || ((col_cur == '0) && (width_eff == WW'(1))));
         s1_keep2_ff    <= col_cur != '0;
         s1_fwd_ff      <= fwd_hit;
         s1_fwd_data_ff <= wb_data;
      end
   end

   // Line RAM: upper half is the row above, lower half the row two above.
   bb_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_WIDTH)
   ) u_lines (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (wb_data),
      .rd_en   (load),
      .rd_addr (col_cur),
      .rd_data (ram_rd)
   );

   // The same column is written and read on one edge at width one, and when a new
   // frame starts straight after the final pixel; bypass the RAM then.
   assign lines   = s1_fwd_ff ? s1_fwd_data_ff : ram_rd;
   assign mid_px  = lines[LW-1:PIX_W];
   assign top_px  = lines[PIX_W-1:0];
   assign wb_data = {s1_pix_ff, mid_px};

   // Column sums per channel, and the masked sum over the shifted window:
   // left, centre and new right column.
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         top_ch = s1_top_keep_ff ? top_px[CHAN_W*(2-ch) +: CHAN_W] : '0;
         mid_ch = s1_mid_keep_ff ? mid_px[CHAN_W*(2-ch) +: CHAN_W] : '0;
         new_col[ch] = COL_W'(top_ch) + COL_W'(mid_ch)
                     + COL_W'(s1_pix_ff[CHAN_W*(2-ch) +: CHAN_W]);
         sum_fixed.chan[ch] = (s1_keep0_ff ? SUM_W'(win_ff[ch][1]) : '0)
                            + SUM_W'(win_ff[ch][2])
                            + (s1_keep2_ff ? SUM_W'(new_col[ch]) : '0);
      end
      sum_fixed.last = s1_last_ff;
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int k = 0; k < 3; k++) begin
            win_in[ch][k] = win_ff[ch][k];
         end
         if (cfg_restart || (s1_adv && s1_last_ff)) begin
            for (int k = 0; k < 3; k++) begin
               win_in[ch][k] = '0;
            end
         end else if (s1_adv) begin
            win_in[ch][0] = win_ff[ch][1];
            win_in[ch][1] = win_ff[ch][2];
            win_in[ch][2] = new_col[ch];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[ch][k] <= '0;
            end
         end
      end else begin
         win_ff <= win_in;
      end
   end

   bb_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .sum_valid (s1_adv && s1_emit_ff),
      .sum_ready (sum_ready),
      .sum_data  (sum_fixed),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue),
      .rsp_last  (rsp_last)
   );

`ifndef SYNTHESIS
   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      WW'(col_ff) < width_eff)
      else $error("column position beyond frame width");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_ff <= height_eff + HW'(1))
      else $error("row position beyond drain row");

   a_bypass_same_col: assert property (@(posedge clock) disable iff (reset)
      (load && fwd_hit) |-> ((width_eff == WW'(1)) || s1_last_ff))
      else $error("line RAM bypass taken outside width one or a frame restart");

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> (win_ff[0][2] == '0 && win_ff[1][2] == '0
                                   && win_ff[2][2] == '0))
      else $error("window not cleared after final pixel");
`endif

endmodule

FILE: tb/box_blur_3x3_checker.sv
`timescale 1ns / 100ps

// Watches both streaming channels and the register port of the blur block.
// Every accepted input transaction is run through a local model of the 3x3
// window, and every accepted result is compared with the oldest prediction.
module box_blur_3x3_checker #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [bb_pkg::CHAN_W-1:0] req_red,
   input  logic [bb_pkg::CHAN_W-1:0] req_green,
   input  logic [bb_pkg::CHAN_W-1:0] req_blue,
   input  logic                      req_drain,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [bb_pkg::CHAN_W-1:0] rsp_red,
   input  logic [bb_pkg::CHAN_W-1:0] rsp_green,
   input  logic [bb_pkg::CHAN_W-1:0] rsp_blue,
   input  logic                      rsp_last,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [bb_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [bb_pkg::CSR_DW-1:0] csr_pwdata,
   input  logic [bb_pkg::CSR_DW-1:0] csr_prdata,
   input  logic                      csr_pready,
   output int unsigned               pending_px,
   output int unsigned               fault_count
);
   import bb_pkg::*;

   localparam int WINDOW_CELLS = 9;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last;
   } blurred_px_type;

   // Local copy of the row stores, the window and the frame position.
   bit [PIX_W-1:0]   prev_row_px [MAX_WIDTH];
   bit [PIX_W-1:0]   prev2_row_px [MAX_WIDTH];
   bit [PIX_W-1:0]   window_px [3][3];
   int unsigned      next_col;
   int unsigned      next_row;
   logic [CFG_W-1:0] width_cfg;
   logic [CFG_W-1:0] height_cfg;
   blurred_px_type   blurred_q [$];
   int unsigned      fault_total = 0;

   // A zero dimension behaves as one, anything above the maximum as the maximum.
   function automatic int unsigned effective_dim(input logic [CFG_W-1:0] raw,
                                                 input int unsigned ceiling);
      if (raw == 0) return 1;
      if (raw > ceiling) return ceiling;
      return raw;
   endfunction

   task automatic rewind_frame();
      next_col = 0;
      next_row = 0;
      foreach (window_px[i, j]) window_px[i][j] = '0;
   endtask

   task automatic note_mismatch(input string what);
      $display("[%0t] box_blur_3x3 checker: %s", $time, what);
      fault_total++;
   endtask

   // Advances the window by one input transaction and queues the pixel it releases.
   task automatic blur_pixel(input logic [CHAN_W-1:0] red, green, blue,
                             input logic drain);
      int unsigned    w, h, r, c, pr, pc;
      int unsigned    sum_r, sum_g, sum_b;
      bit [PIX_W-1:0] px_in, above2, above1, nbr_px;
      bit             emit;
      blurred_px_type px_out;
      w = effective_dim(width_cfg, MAX_WIDTH);
      h = effective_dim(height_cfg, MAX_HEIGHT);
      r = next_row;
      c = (next_col >= w) ? 0 : next_col;
      // A drain at the very start of a frame leaves no trace at all.
      if (drain && r == 0 && c == 0) return;
      // Drains and pixels beyond the last row enter the window as black.
      px_in = (!drain && r < h) ? {red, green, blue} : '0;
      above2 = prev2_row_px[c];
      above1 = prev_row_px[c];
      prev2_row_px[c] = above1;
      prev_row_px[c] = px_in;
      for (int k = 0; k < 3; k++) begin
         window_px[k][0] = window_px[k][1];
         window_px[k][1] = window_px[k][2];
      end
      window_px[0][2] = above2;
      window_px[1][2] = above1;
      window_px[2][2] = px_in;
      // The centre of the window trails the input by one row and one column.
      emit = (r >= 2) || (r == 1 && c >= 1);
      if (c >= 1) begin
         pr = r - 1;
         pc = c - 1;
      end else begin
         pr = (r >= 2) ? r - 2 : 0;
         pc = w - 1;
      end
      px_out.last = emit && c == 0 && r == h + 1;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
      end
      next_col = c;
      next_row = r;
      if (!emit) return;
      // Sum the neighbours that lie inside the frame; the rest count as zero.
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      for (int dr = 0; dr < 3; dr++) begin
         for (int dc = 0; dc < 3; dc++) begin
            if ((dr == 0 && pr == 0) || (dr == 2 && pr + 1 >= h) ||
                (dc == 0 && pc == 0) || (dc == 2 && pc + 1 >= w)) continue;
            nbr_px = window_px[dr][dc];
            sum_r += nbr_px[2*CHAN_W +: CHAN_W];
            sum_g += nbr_px[CHAN_W +: CHAN_W];
            sum_b += nbr_px[0 +: CHAN_W];
         end
      end
      px_out.red = CHAN_W'(sum_r / WINDOW_CELLS);
      px_out.green = CHAN_W'(sum_g / WINDOW_CELLS);
      px_out.blue = CHAN_W'(sum_b / WINDOW_CELLS);
      blurred_q.push_back(px_out);
      if (px_out.last) rewind_frame();
   endtask

   task automatic check_result();
      blurred_px_type want;
      if (blurred_q.size() == 0) begin
         note_mismatch($sformatf("result %0d/%0d/%0d last=%0b with none expected",
                                 rsp_red, rsp_green, rsp_blue, rsp_last));
         return;
      end
      want = blurred_q.pop_front();
      if (rsp_red !== want.red)
         note_mismatch($sformatf("red got %0d, expected %0d", rsp_red, want.red));
      if (rsp_green !== want.green)
         note_mismatch($sformatf("green got %0d, expected %0d", rsp_green, want.green));
      if (rsp_blue !== want.blue)
         note_mismatch($sformatf("blue got %0d, expected %0d", rsp_blue, want.blue));
      if (rsp_last !== want.last)
         note_mismatch($sformatf("last got %0b, expected %0b", rsp_last, want.last));
   endtask

   always @(posedge clock) begin : watch
      logic [CFG_W-1:0] held;
      if (reset) begin
         width_cfg = CFG_RESET;
         height_cfg = CFG_RESET;
         rewind_frame();
         blurred_q.delete();
      end else begin
         // Register transactions: a write restarts the frame, a read returns the value.
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_paddr[CSR_AW-1:2] == REG_FRAME_WIDTH) held = width_cfg;
            else held = height_cfg;
            if (csr_pwrite) begin
               if (csr_paddr[CSR_AW-1:2] == REG_FRAME_WIDTH) begin
                  width_cfg = csr_pwdata[CFG_W-1:0];
                  rewind_frame();
               end else if (csr_paddr[CSR_AW-1:2] == REG_FRAME_HEIGHT) begin
                  height_cfg = csr_pwdata[CFG_W-1:0];
                  rewind_frame();
               end
            end else if (csr_prdata !== CSR_DW'(held)) begin
               note_mismatch($sformatf("register read at %0d got %0d, expected %0d",
                                       csr_paddr, csr_prdata, held));
            end
         end
         if (req_valid && req_ready) blur_pixel(req_red, req_green, req_blue, req_drain);
         if (rsp_valid && rsp_ready) check_result();
      end
      pending_px <= blurred_q.size();
      fault_count <= fault_total;
   end

endmodule

FILE: tb/box_blur_3x3_tb.sv
`timescale 1ns / 100ps

module box_blur_3x3_tb;
   import bb_pkg::*;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CHAN_W-1:0] req_red = '0;
   logic [CHAN_W-1:0] req_green = '0;
   logic [CHAN_W-1:0] req_blue = '0;
   logic              req_drain = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CHAN_W-1:0] rsp_red;
   logic [CHAN_W-1:0] rsp_green;
   logic [CHAN_W-1:0] rsp_blue;
   logic              rsp_last;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int unsigned pending_px;
   int unsigned fault_count;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned stalls_asked = 0;
   int unsigned stalls_granted = 0;
   int unsigned stall_left = 0;
   int unsigned items_sent = 0;
   int unsigned frame_w = MAX_WIDTH;
   int unsigned frame_h = MAX_HEIGHT;

   always #5 clock = ~clock;

   box_blur_3x3 #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) dut (.*);

   box_blur_3x3_checker #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) blur_check (.*);

   // Result side: random back-pressure, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stalls_granted != stalls_asked) begin
         rsp_ready <= 1'b0;
         stall_left <= 400;
         stalls_granted <= stalls_granted + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      #2_000_000;
      $display("box_blur_3x3 regression: fail");
      $finish;
   end

   // Offers one input transaction, after random idle cycles, and waits for acceptance.
   task automatic push_px(input logic [CHAN_W-1:0] red, green, blue, input logic drain);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red <= red;
      req_green <= green;
      req_blue <= blue;
      req_drain <= drain;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Lets every outstanding result arrive, then a little longer for trailing work.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_px != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_access(input logic is_write, input logic sel,
                             input logic [CFG_W-1:0] value);
      logic [CSR_DW-1:0] word;
      word = $urandom();
      word[CFG_W-1:0] = value;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= CSR_AW'({sel, 2'b00});
      csr_pwdata <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Out-of-range encodings stand in for the extreme sizes now and then.
   function automatic logic [CFG_W-1:0] raw_dim(input int unsigned eff,
                                                input int unsigned ceiling,
                                                input bit odd);
      if (eff == 1 && (odd || $urandom_range(3) == 0)) return '0;
      if (eff == ceiling && odd) return '1;
      if (eff == ceiling && $urandom_range(1) == 0)
         return CFG_W'(ceiling + $urandom_range(1, 1023));
      return CFG_W'(eff);
   endfunction

   task automatic configure(input int unsigned w, input int unsigned h, input bit odd);
      settle();
      csr_access(1'b1, REG_FRAME_WIDTH, raw_dim(w, MAX_WIDTH, odd));
      csr_access(1'b1, REG_FRAME_HEIGHT, raw_dim(h, MAX_HEIGHT, odd));
      csr_access(1'b0, REG_FRAME_WIDTH, '0);
      csr_access(1'b0, REG_FRAME_HEIGHT, '0);
      frame_w = w;
      frame_h = h;
   endtask

   // One frame of random content, optionally cut short before its flush.
   task automatic run_frame(input bit broken);
      int unsigned n, fill;
      fill = $urandom_range(9);
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(1, 2))
            push_px($urandom_range(255), $urandom_range(255), $urandom_range(255), 1'b1);
      n = broken ? $urandom_range(1, frame_w * frame_h) : frame_w * frame_h;
      repeat (n) begin
         if ($urandom_range(19) == 0)
            push_px($urandom_range(255), $urandom_range(255), $urandom_range(255), 1'b1);
         else if (fill == 0)
            push_px(8'hFF, 8'hFF, 8'hFF, 1'b0);
         else if (fill == 1)
            push_px(8'h00, 8'h00, 8'h00, 1'b0);
         else
            push_px($urandom_range(255), $urandom_range(255), $urandom_range(255), 1'b0);
      end
      items_sent += n;
      // The flush is mostly drains; a pixel past the last row acts as one.
      if (!broken) begin
         repeat (frame_w + 1)
            push_px($urandom_range(255), $urandom_range(255), $urandom_range(255),
                    $urandom_range(4) != 0);
         items_sent += frame_w + 1;
      end
   endtask

   initial begin
      int unsigned phase_end, waited;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 26;
      recv_idle_pct = 67;

      // A drain straight after reset is dropped; two pixels into the default frame.
      push_px(8'h00, 8'h00, 8'h00, 1'b1);
      push_px(8'hFF, 8'hFF, 8'hFF, 1'b0);
      push_px(8'hFF, 8'hFF, 8'hFF, 1'b0);

      // Three by three: saturated pixels, one black and one drain in the middle,
      // and a flush that mixes drains with pixels beyond the last row.
      configure(3, 3, 1'b0);
      push_px(8'hFF, 8'hFF, 8'hFF, 1'b1);
      for (int k = 0; k < 9; k++) begin
         if (k == 4) push_px(8'hFF, 8'hFF, 8'hFF, 1'b1);
         else if (k == 5) push_px(8'h00, 8'h00, 8'h00, 1'b0);
         else push_px(8'hFF, 8'hFF, 8'hFF, 1'b0);
      end
      push_px(8'h00, 8'h00, 8'h00, 1'b1);
      push_px(8'h00, 8'h00, 8'h00, 1'b1);
      push_px(8'h5A, 8'hC3, 8'h0F, 1'b0);
      push_px(8'hFF, 8'hFF, 8'hFF, 1'b0);

      // Zero written to both registers gives a single-pixel frame.
      configure(1, 1, 1'b1);
      push_px(8'hFF, 8'h00, 8'hA5, 1'b0);
      push_px(8'h00, 8'h00, 8'h00, 1'b1);
      push_px(8'h00, 8'h00, 8'h00, 1'b1);

      // Random frames under three idling patterns.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 67 : 0;
         recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 26 : 0;
         phase_end = items_sent + 300;
         configure($urandom_range(1, 8), $urandom_range(1, 6), 1'b0);
         while (items_sent < phase_end) begin
            if ($urandom_range(3) == 0)
               configure($urandom_range(1, 8), $urandom_range(1, 6), 1'b0);
            run_frame($urandom_range(19) == 0);
         end
      end

      // Long hold-off on the result side while the sender keeps offering.
      configure(8, 8, 1'b0);
      stalls_asked++;
      run_frame(1'b0);

      req_valid <= 1'b0;
      waited = 0;
      while (pending_px != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (fault_count == 0 && pending_px == 0) begin
         $display("box_blur_3x3 regression: pass");
      end else begin
         if (pending_px != 0) $display("%0d expected results never arrived", pending_px);
         $display("box_blur_3x3 regression: fail");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/bb_pkg.sv
design/bb_ram.sv
design/bb_csr.sv
design/bb_divide.sv
design/box_blur_3x3.sv
tb/box_blur_3x3_checker.sv
tb/box_blur_3x3_tb.sv
